// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker in ftpr_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/ftpr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ftpr_pkg;

  localparam int unsigned RingDepthDefault  = 64;
  localparam int unsigned MaxClientsDefault = 1024;

  localparam int unsigned CfgW          = 7;
  localparam int unsigned CfgResetSlots = 64;

  localparam int unsigned CmdW      = 3;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned SlotIdxW  = 6;
  localparam int unsigned OpcodeW   = 8;
  localparam int unsigned KeyW      = 64;
  localparam int unsigned AddrW     = 48;
  localparam int unsigned ClientW   = 10;
  localparam int unsigned FragW     = 16;
  localparam int unsigned SeqW      = 32;

  typedef logic [CmdW-1:0]    cmd_t;
  typedef logic [StatusW-1:0] status_t;

  localparam cmd_t CmdPushSmall = 3'd0;
  localparam cmd_t CmdPushLarge = 3'd1;
  localparam cmd_t CmdUpdate    = 3'd2;
  localparam cmd_t CmdPop       = 3'd3;
  localparam cmd_t CmdQuery     = 3'd4;

  localparam status_t StatusOk       = 3'd0;
  localparam status_t StatusFull     = 3'd1;
  localparam status_t StatusEmpty    = 3'd2;
  localparam status_t StatusNoClient = 3'd3;
  localparam status_t StatusStale    = 3'd4;
  localparam status_t StatusDup      = 3'd5;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [KeyW-1:0]    key;
    logic [AddrW-1:0]   address;
    logic [FragW-1:0]   frag_count;
    logic [FragW-1:0]   frag_total;
    logic [ClientW-1:0] client;
    logic [SeqW-1:0]    seq_num;
  } slot_entry_t;

  typedef struct packed {
    status_t               status;
    logic [SlotIdxW-1:0]   slot_index;
    slot_entry_t           entry;
    logic                  rewrite_header;
  } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/ftpr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ftpr_req_if import ftpr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CmdW-1:0]    command;
  logic [OpcodeW-1:0] opcode;
  logic [KeyW-1:0]    request_key;
  logic [AddrW-1:0]   client_address;
  logic [ClientW-1:0] client_index;
  logic [FragW-1:0]   fragment_count;
  logic [FragW-1:0]   fragment_total;
  logic [SeqW-1:0]    sequence_number;
  logic               is_first_fragment;

  modport source (
    output valid, command, opcode, request_key, client_address, client_index,
           fragment_count, fragment_total, sequence_number, is_first_fragment,
    input  ready
  );
  modport sink (
    input  valid, command, opcode, request_key, client_address, client_index,
           fragment_count, fragment_total, sequence_number, is_first_fragment,
    output ready
  );
endinterface

interface ftpr_rsp_if import ftpr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [StatusW-1:0]  status;
  logic [SlotIdxW-1:0] slot_index;
  logic [OpcodeW-1:0]  out_opcode;
  logic [KeyW-1:0]     out_key;
  logic [AddrW-1:0]    out_client_address;
  logic [FragW-1:0]    out_fragment_count;
  logic [FragW-1:0]    out_fragment_total;
  logic [ClientW-1:0]  out_client_index;
  logic [SeqW-1:0]     out_sequence;
  logic                rewrite_header;

  modport source (
    output valid, status, slot_index, out_opcode, out_key, out_client_address,
           out_fragment_count, out_fragment_total, out_client_index, out_sequence,
           rewrite_header,
    input  ready
  );
  modport sink (
    input  valid, status, slot_index, out_opcode, out_key, out_client_address,
           out_fragment_count, out_fragment_total, out_client_index, out_sequence,
           rewrite_header,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/fragment_tracking_packet_ring_core.sv -----
// Request descriptor ring with a per-client index of pending large requests.
// Requests arrive on the req channel (valid/ready) and carry one command: push
// small, push large, update large, pop or query client. Every request with a
// defined command returns exactly one response on the rsp channel; commands 5
// to 7 are taken and dropped. The ring size register is written through
// cfg_we_i/cfg_wdata_i and empties the ring; the user must write it only while
// the block is idle; the block does not enforce this. Pushes, pops and
// requests for an unknown client pass through StMap before the response is
// registered; updates and queries that find their client pass through StMap
// and then StSlot. The sequencer handles one request at a time and waits on
// the read of the client map and then of the slot memory, so it takes a new
// request only once the last response is registered. Reset and every cfg
// write clears all MAX_CLIENTS map entries, one per cycle, with req.ready low.
// The response sits in an output register. While the receiver stalls, one
// more request is accepted and then waits in the sequencer until the output
// register is taken.
`timescale 1ns / 1ps
`default_nettype none

module fragment_tracking_packet_ring_core import ftpr_pkg::*; #(
  parameter int unsigned RING_DEPTH  = RingDepthDefault,
  parameter int unsigned MAX_CLIENTS = MaxClientsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  ftpr_req_if.sink        req,
  ftpr_rsp_if.source      rsp
);

  localparam int unsigned PtrW    = $clog2(RING_DEPTH);
  localparam int unsigned CapW    = PtrW + 1;
  localparam int unsigned CmpW    = CapW + CfgW;
  localparam int unsigned MapAw   = $clog2(MAX_CLIENTS);
  localparam int unsigned CliCmpW = ($clog2(MAX_CLIENTS + 1) > ClientW) ?
                                    $clog2(MAX_CLIENTS + 1) : ClientW;
  localparam int unsigned CapResetInt = (CfgResetSlots > RING_DEPTH) ?
                                        RING_DEPTH : CfgResetSlots;
  localparam logic [CapW-1:0] CapReset = CapW'(CapResetInt);

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StMap,
    StSlot
  } state_e;

  typedef struct packed {
    cmd_t               command;
    logic [OpcodeW-1:0] opcode;
    logic [KeyW-1:0]    key;
    logic [AddrW-1:0]   address;
    logic [ClientW-1:0] client;
    logic [FragW-1:0]   frag_count;
    logic [FragW-1:0]   frag_total;
    logic [SeqW-1:0]    seq_num;
    logic               first;
  } req_t;

  function automatic logic [PtrW-1:0] advance(input logic [PtrW-1:0] p,
                                              input logic [CapW-1:0] cap);
    logic [CapW-1:0] n;
    n = CapW'(p) + CapW'(1);
    return (n >= cap) ? '0 : n[PtrW-1:0];
  endfunction

  function automatic logic [SlotIdxW-1:0] slot_idx(input logic [PtrW-1:0] s);
    logic [PtrW+SlotIdxW-1:0] e;
    e = (PtrW + SlotIdxW)'(s);
    return e[SlotIdxW-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [CapW-1:0]   cap_q, cap_d;
  logic [PtrW-1:0]   wp_q, wp_d;
  logic [PtrW-1:0]   rp_q, rp_d;
  logic [MapAw-1:0]  clr_q, clr_d;
  req_t              req_q, req_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  // Client map: valid bit on top of the slot pointer.
  logic [PtrW:0]     map_mem [MAX_CLIENTS];
  logic              map_we;
  logic [MapAw-1:0]  map_waddr;
  logic [PtrW:0]     map_wdata;
  logic              map_re;
  logic [MapAw-1:0]  map_raddr;
  logic [PtrW:0]     map_rd_q;

  slot_entry_t       slot_mem [RING_DEPTH];
  logic              slot_we;
  logic [PtrW-1:0]   slot_waddr;
  slot_entry_t       slot_wdata;
  logic              slot_re;
  logic [PtrW-1:0]   slot_raddr;
  slot_entry_t       slot_rd_q;

  logic [CmpW-1:0]    cfg_ext;
  logic [CapW-1:0]    cap_new;
  logic [CliCmpW-1:0] in_cli_ext;
  logic [CliCmpW-1:0] req_cli_ext;
  logic [CliCmpW-1:0] pop_cli_ext;
  logic               req_cli_ok;
  logic               pop_cli_ok;
  logic               out_free;
  logic               ring_full;
  slot_entry_t        push_entry;
  slot_entry_t        upd_entry;
  rsp_t               res;

  assign req.ready = (state_q == StIdle);
  assign out_free  = !out_valid_q || rsp.ready;

  assign in_cli_ext  = CliCmpW'(req.client_index);
  assign req_cli_ext = CliCmpW'(req_q.client);
  assign pop_cli_ext = CliCmpW'(slot_rd_q.client);
  assign req_cli_ok  = req_cli_ext < CliCmpW'(MAX_CLIENTS);
  assign pop_cli_ok  = pop_cli_ext < CliCmpW'(MAX_CLIENTS);
  assign ring_full   = (advance(wp_q, cap_q) == rp_q);

  // Clamp the written ring size into the range the memory supports.
  always_comb begin
    cfg_ext = CmpW'(cfg_wdata_i);
    if (cfg_ext < CmpW'(2)) begin
      cap_new = CapW'(2);
    end else if (cfg_ext > CmpW'(RING_DEPTH)) begin
      cap_new = CapW'(RING_DEPTH);
    end else begin
      cap_new = cfg_ext[CapW-1:0];
    end
  end

  always_comb begin
    push_entry.opcode  = req_q.opcode;
    push_entry.key     = req_q.key;
    push_entry.address = req_q.address;
    if (req_q.command == CmdPushLarge) begin
      push_entry.frag_count = req_q.frag_count;
      push_entry.frag_total = (req_q.frag_total == '0) ? FragW'(1) : req_q.frag_total;
      push_entry.client     = req_q.client;
      push_entry.seq_num    = req_q.seq_num;
    end else begin
      push_entry.frag_count = '0;
      push_entry.frag_total = '0;
      push_entry.client     = '0;
      push_entry.seq_num    = '0;
    end
  end

  // A newer sequence number restarts the count; otherwise it saturates upward.
  always_comb begin
    upd_entry = slot_rd_q;
    if (req_q.seq_num > slot_rd_q.seq_num) begin
      upd_entry.seq_num    = req_q.seq_num;
      upd_entry.frag_count = FragW'(1);
    end else if (slot_rd_q.frag_count != '1) begin
      upd_entry.frag_count = slot_rd_q.frag_count + FragW'(1);
    end
  end

  always_comb begin
    state_d     = state_q;
    cap_d       = cap_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    clr_d       = clr_q;
    req_d       = req_q;
    out_valid_d = out_valid_q && !rsp.ready;
    out_d       = out_q;
    map_we      = 1'b0;
    map_waddr   = clr_q;
    map_wdata   = '0;
    map_re      = 1'b0;
    map_raddr   = in_cli_ext[MapAw-1:0];
    slot_we     = 1'b0;
    slot_waddr  = wp_q;
    slot_wdata  = push_entry;
    slot_re     = 1'b0;
    slot_raddr  = rp_q;
    res         = '0;

    case (state_q)
      StClear: begin
        map_we = 1'b1;
        clr_d  = clr_q + MapAw'(1);
        if (clr_q == MapAw'(MAX_CLIENTS - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (req.valid) begin
          req_d.command    = req.command;
          req_d.opcode     = req.opcode;
          req_d.key        = req.request_key;
          req_d.address    = req.client_address;
          req_d.client     = req.client_index;
          req_d.frag_count = req.fragment_count;
          req_d.frag_total = req.fragment_total;
          req_d.seq_num    = req.sequence_number;
          req_d.first      = req.is_first_fragment;
          map_re  = 1'b1;
          slot_re = 1'b1;
          if (req.command inside {[CmdPushSmall:CmdQuery]}) begin
            state_d = StMap;
          end
        end
      end
      StMap: begin
        if (out_free) begin
          case (req_q.command)
            CmdPushSmall, CmdPushLarge: begin
              if (ring_full) begin
                res.status = StatusFull;
              end else if (req_q.command == CmdPushLarge && !req_cli_ok) begin
                res.status = StatusNoClient;
              end else if (req_q.command == CmdPushLarge && map_rd_q[PtrW]) begin
                res.status = StatusDup;
              end else begin
                slot_we = 1'b1;
                if (req_q.command == CmdPushLarge) begin
                  map_we    = 1'b1;
                  map_waddr = req_cli_ext[MapAw-1:0];
                  map_wdata = {1'b1, wp_q};
                end
                wp_d           = advance(wp_q, cap_q);
                res.status     = StatusOk;
                res.slot_index = slot_idx(wp_q);
                res.entry      = push_entry;
              end
              out_valid_d = 1'b1;
              out_d       = res;
              state_d     = StIdle;
            end
            CmdPop: begin
              if (rp_q == wp_q) begin
                res.status = StatusEmpty;
              end else begin
                if (slot_rd_q.frag_total != '0 && pop_cli_ok) begin
                  map_we    = 1'b1;
                  map_waddr = pop_cli_ext[MapAw-1:0];
                  map_wdata = '0;
                end
                rp_d           = advance(rp_q, cap_q);
                res.status     = StatusOk;
                res.slot_index = slot_idx(rp_q);
                res.entry      = slot_rd_q;
              end
              out_valid_d = 1'b1;
              out_d       = res;
              state_d     = StIdle;
            end
            CmdUpdate, CmdQuery: begin
              if (!req_cli_ok || !map_rd_q[PtrW]) begin
                res.status  = StatusNoClient;
                out_valid_d = 1'b1;
                out_d       = res;
                state_d     = StIdle;
              end else begin
                slot_re    = 1'b1;
                slot_raddr = map_rd_q[PtrW-1:0];
                state_d    = StSlot;
              end
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end
      StSlot: begin
        if (out_free) begin
          if (req_q.command == CmdUpdate) begin
            if (req_q.seq_num < slot_rd_q.seq_num) begin
              res.status = StatusStale;
            end else begin
              slot_we            = 1'b1;
              slot_waddr         = map_rd_q[PtrW-1:0];
              slot_wdata         = upd_entry;
              res.status         = StatusOk;
              res.slot_index     = slot_idx(map_rd_q[PtrW-1:0]);
              res.entry          = upd_entry;
              res.rewrite_header = (upd_entry.frag_count == FragW'(1)) || req_q.first;
            end
          end else begin
            res.status     = StatusOk;
            res.slot_index = slot_idx(map_rd_q[PtrW-1:0]);
            res.entry      = slot_rd_q;
          end
          out_valid_d = 1'b1;
          out_d       = res;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // A ring size write empties the ring and sweeps the client map again.
    if (cfg_we_i) begin
      cap_d   = cap_new;
      wp_d    = '0;
      rp_d    = '0;
      clr_d   = '0;
      state_d = StClear;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      cap_q       <= CapReset;
      wp_q        <= '0;
      rp_q        <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      map_rd_q <= map_mem[map_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_raddr];
    end
  end

  assign rsp.valid              = out_valid_q;
  assign rsp.status             = out_q.status;
  assign rsp.slot_index         = out_q.slot_index;
  assign rsp.out_opcode         = out_q.entry.opcode;
  assign rsp.out_key            = out_q.entry.key;
  assign rsp.out_client_address = out_q.entry.address;
  assign rsp.out_fragment_count = out_q.entry.frag_count;
  assign rsp.out_fragment_total = out_q.entry.frag_total;
  assign rsp.out_client_index   = out_q.entry.client;
  assign rsp.out_sequence       = out_q.entry.seq_num;
  assign rsp.rewrite_header     = out_q.rewrite_header;

endmodule

`default_nettype wire

// ----- rtl/ftpr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ftpr_checker import ftpr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic [CmdW-1:0]     req_command_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [StatusW-1:0]  rsp_status_i,
  input logic [SlotIdxW-1:0] rsp_slot_index_i,
  input logic [KeyW-1:0]     rsp_out_key_i,
  input logic [FragW-1:0]    rsp_out_fragment_total_i,
  input logic                rsp_rewrite_header_i
);

  logic rsp_err;
  logic req_work;

  assign rsp_err  = rsp_valid_i && (rsp_status_i != StatusOk);
  assign req_work = req_valid_i && req_ready_i && (req_command_i <= CmdQuery);

  // A pending response is never dropped before it is taken.
  `ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i)

  // One request at a time: a taken request with a defined command blocks the next cycle.
  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_work, !req_ready_i)

  // A refused request reports nothing but its status.
  `ASSERT_ALWAYS(a_err_zero, clk_i, rst_ni, !rsp_err || (rsp_slot_index_i == '0 && rsp_out_key_i == '0 && rsp_out_fragment_total_i == '0))

  // A header rewrite is only ever requested by a successful operation.
  `ASSERT_ALWAYS(a_rewrite_ok, clk_i, rst_ni, !(rsp_valid_i && rsp_rewrite_header_i) || rsp_status_i == StatusOk)

endmodule

bind fragment_tracking_packet_ring_core ftpr_checker u_ftpr_checker (
  .clk_i                    (clk_i),
  .rst_ni                   (rst_ni),
  .req_valid_i              (req.valid),
  .req_ready_i              (req.ready),
  .req_command_i            (req.command),
  .rsp_valid_i              (rsp.valid),
  .rsp_ready_i              (rsp.ready),
  .rsp_status_i             (rsp.status),
  .rsp_slot_index_i         (rsp.slot_index),
  .rsp_out_key_i            (rsp.out_key),
  .rsp_out_fragment_total_i (rsp.out_fragment_total),
  .rsp_rewrite_header_i     (rsp.rewrite_header)
);

`default_nettype wire

// ----- tb/fragment_tracking_packet_ring_core_tb.sv -----
`timescale 1ns / 1ps

module fragment_tracking_packet_ring_core_tb;
  import ftpr_pkg::*;

  localparam int unsigned CycleLimit     = 1000000;
  localparam int unsigned SettleCycles   = 12;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned PhaseRequests  = 214;
  localparam int unsigned ClientPool     = 8;
  localparam int unsigned MaxPrinted     = 200;
  localparam int unsigned RingSizes [7]  = '{64, 3, 63, 17, 2, 40, 64};

  typedef struct packed {
    cmd_t               command;
    logic [OpcodeW-1:0] opcode;
    logic [KeyW-1:0]    request_key;
    logic [AddrW-1:0]   client_address;
    logic [ClientW-1:0] client_index;
    logic [FragW-1:0]   fragment_count;
    logic [FragW-1:0]   fragment_total;
    logic [SeqW-1:0]    sequence_number;
    logic               is_first_fragment;
  } request_t;

  // Mirror of the ring, the slot contents and the client index.
  class ring_tracker;
    int unsigned ring_size;
    int unsigned wr_ptr;
    int unsigned rd_ptr;
    slot_entry_t slots [RingDepthDefault];
    bit          client_mapped [MaxClientsDefault];
    int unsigned client_slot [MaxClientsDefault];
    rsp_t        pending_rsp [$];
    int unsigned mismatches;

    function new();
      ring_size  = CfgResetSlots;
      mismatches = 0;
      foreach (slots[i]) slots[i] = '0;
      clear_ring();
    endfunction

    function void clear_ring();
      wr_ptr = 0;
      rd_ptr = 0;
      foreach (client_mapped[i]) begin
        client_mapped[i] = 1'b0;
        client_slot[i]   = 0;
      end
    endfunction

    function void configure(logic [CfgW-1:0] value);
      if (value < 2) begin
        ring_size = 2;
      end else if (value > RingDepthDefault) begin
        ring_size = RingDepthDefault;
      end else begin
        ring_size = value;
      end
      clear_ring();
    endfunction

    function int unsigned next_slot(int unsigned p);
      return (p + 1 >= ring_size) ? 0 : p + 1;
    endfunction

    function void accept_request(request_t r);
      rsp_t        want;
      int unsigned s;
      want = '0;
      if (r.command > CmdQuery) return;
      case (r.command)
        CmdPushSmall, CmdPushLarge: begin
          if (next_slot(wr_ptr) == rd_ptr) begin
            want.status = StatusFull;
          end else if (r.command == CmdPushLarge && client_mapped[r.client_index]) begin
            want.status = StatusDup;
          end else begin
            s = wr_ptr;
            slots[s].opcode  = r.opcode;
            slots[s].key     = r.request_key;
            slots[s].address = r.client_address;
            if (r.command == CmdPushSmall) begin
              slots[s].frag_count = '0;
              slots[s].frag_total = '0;
              slots[s].client     = '0;
              slots[s].seq_num    = '0;
            end else begin
              slots[s].frag_count = r.fragment_count;
              slots[s].frag_total = (r.fragment_total == 0) ? 16'd1 : r.fragment_total;
              slots[s].client     = r.client_index;
              slots[s].seq_num    = r.sequence_number;
              client_mapped[r.client_index] = 1'b1;
              client_slot[r.client_index]   = s;
            end
            wr_ptr          = next_slot(wr_ptr);
            want.status     = StatusOk;
            want.slot_index = s;
            want.entry      = slots[s];
          end
        end
        CmdPop: begin
          if (rd_ptr == wr_ptr) begin
            want.status = StatusEmpty;
          end else begin
            s = rd_ptr;
            want.status     = StatusOk;
            want.slot_index = s;
            want.entry      = slots[s];
            if (slots[s].frag_total != 0) client_mapped[slots[s].client] = 1'b0;
            rd_ptr = next_slot(rd_ptr);
          end
        end
        default: begin
          if (!client_mapped[r.client_index]) begin
            want.status = StatusNoClient;
          end else begin
            s = client_slot[r.client_index];
            if (r.command == CmdUpdate && r.sequence_number < slots[s].seq_num) begin
              want.status = StatusStale;
            end else begin
              if (r.command == CmdUpdate) begin
                // A newer sequence number means the client retried from scratch.
                if (r.sequence_number > slots[s].seq_num) begin
                  slots[s].seq_num    = r.sequence_number;
                  slots[s].frag_count = 16'd1;
                end else if (slots[s].frag_count != 16'hFFFF) begin
                  slots[s].frag_count = slots[s].frag_count + 16'd1;
                end
                want.rewrite_header = (slots[s].frag_count == 16'd1) || r.is_first_fragment;
              end
              want.status     = StatusOk;
              want.slot_index = s;
              want.entry      = slots[s];
            end
          end
        end
      endcase
      pending_rsp.push_back(want);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= MaxPrinted) begin
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      end
    endtask

    task check_response(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        report_mismatch("response with no request outstanding", got.status, 0);
        return;
      end
      want = pending_rsp.pop_front();
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.slot_index !== want.slot_index)
        report_mismatch("slot_index", got.slot_index, want.slot_index);
      if (got.entry.opcode !== want.entry.opcode)
        report_mismatch("out_opcode", got.entry.opcode, want.entry.opcode);
      if (got.entry.key !== want.entry.key)
        report_mismatch("out_key", got.entry.key, want.entry.key);
      if (got.entry.address !== want.entry.address)
        report_mismatch("out_client_address", got.entry.address, want.entry.address);
      if (got.entry.frag_count !== want.entry.frag_count)
        report_mismatch("out_fragment_count", got.entry.frag_count, want.entry.frag_count);
      if (got.entry.frag_total !== want.entry.frag_total)
        report_mismatch("out_fragment_total", got.entry.frag_total, want.entry.frag_total);
      if (got.entry.client !== want.entry.client)
        report_mismatch("out_client_index", got.entry.client, want.entry.client);
      if (got.entry.seq_num !== want.entry.seq_num)
        report_mismatch("out_sequence", got.entry.seq_num, want.entry.seq_num);
      if (got.rewrite_header !== want.rewrite_header)
        report_mismatch("rewrite_header", got.rewrite_header, want.rewrite_header);
    endtask
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  logic [CfgW-1:0] cfg_wdata;

  ftpr_req_if req_if ();
  ftpr_rsp_if rsp_if ();

  fragment_tracking_packet_ring_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req         (req_if),
    .rsp         (rsp_if)
  );

  ring_tracker sb;
  rsp_t        seen;
  bit          hold_asked;
  int unsigned send_stretch_left;
  bit          send_steady;
  int unsigned cycle_count;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      seen.status           = rsp_if.status;
      seen.slot_index       = rsp_if.slot_index;
      seen.entry.opcode     = rsp_if.out_opcode;
      seen.entry.key        = rsp_if.out_key;
      seen.entry.address    = rsp_if.out_client_address;
      seen.entry.frag_count = rsp_if.out_fragment_count;
      seen.entry.frag_total = rsp_if.out_fragment_total;
      seen.entry.client     = rsp_if.out_client_index;
      seen.entry.seq_num    = rsp_if.out_sequence;
      seen.rewrite_header   = rsp_if.rewrite_header;
      sb.check_response(seen);
    end
  end

  // Response side back-pressure: steady stretches, short random stalls, rare
  // long ones, and one very long hold so that the request side fills up.
  initial begin
    int unsigned stall_left;
    int unsigned stretch_left;
    int unsigned r;
    bit          steady;
    stall_left   = 0;
    stretch_left = 0;
    steady       = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asked) begin
        hold_asked = 1'b0;
        stall_left = LongHoldCycles;
      end
      if (stall_left != 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          steady       = ($urandom_range(0, 3) == 0);
          stretch_left = $urandom_range(20, 150);
        end
        stretch_left--;
        r = $urandom_range(0, 99);
        if (steady || r < 70) begin
          rsp_if.ready <= 1'b1;
        end else begin
          rsp_if.ready <= 1'b0;
          stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("fragment_tracking_packet_ring_core verification failed");
    $finish;
  end

  function automatic int unsigned next_gap();
    int unsigned r;
    if (send_stretch_left == 0) begin
      send_steady       = ($urandom_range(0, 3) == 0);
      send_stretch_left = $urandom_range(20, 150);
    end
    send_stretch_left--;
    r = $urandom_range(0, 99);
    if (send_steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic request_t build(cmd_t c, logic [ClientW-1:0] client,
                                     logic [FragW-1:0] cnt, logic [FragW-1:0] tot,
                                     logic [SeqW-1:0] seq_num, logic first);
    request_t r;
    r.command           = c;
    r.opcode            = $urandom_range(0, 255);
    r.request_key       = {$urandom, $urandom};
    r.client_address    = {16'($urandom), $urandom};
    r.client_index      = client;
    r.fragment_count    = cnt;
    r.fragment_total    = tot;
    r.sequence_number   = seq_num;
    r.is_first_fragment = first;
    return r;
  endfunction

  function automatic request_t random_request();
    int unsigned      r;
    cmd_t             c;
    logic [ClientW-1:0] client;
    logic [FragW-1:0] cnt;
    logic [FragW-1:0] tot;
    logic [SeqW-1:0]  seq_num;
    r = $urandom_range(0, 99);
    if (r < 18) begin
      c = CmdPushSmall;
    end else if (r < 40) begin
      c = CmdPushLarge;
    end else if (r < 68) begin
      c = CmdUpdate;
    end else if (r < 90) begin
      c = CmdPop;
    end else if (r < 97) begin
      c = CmdQuery;
    end else begin
      c = cmd_t'(CmdQuery + $urandom_range(1, 3));
    end
    // A small pool of clients keeps large requests meeting their updates.
    client = ($urandom_range(0, 99) < 85) ? $urandom_range(0, ClientPool - 1)
                                          : $urandom_range(0, 1023);
    r = $urandom_range(0, 99);
    if (r < 70) begin
      seq_num = $urandom_range(0, 6);
    end else if (r < 92) begin
      seq_num = $urandom;
    end else begin
      seq_num = '1;
    end
    r = $urandom_range(0, 99);
    if (r < 45) begin
      cnt = $urandom_range(0, 65535);
    end else if (r < 80) begin
      cnt = $urandom_range(0, 3);
    end else begin
      cnt = $urandom_range(65533, 65535);
    end
    tot = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
    return build(c, client, cnt, tot, seq_num, $urandom_range(0, 1));
  endfunction

  task automatic issue(request_t r);
    int unsigned gap;
    gap = next_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid             <= 1'b1;
    req_if.command           <= r.command;
    req_if.opcode            <= r.opcode;
    req_if.request_key       <= r.request_key;
    req_if.client_address    <= r.client_address;
    req_if.client_index      <= r.client_index;
    req_if.fragment_count    <= r.fragment_count;
    req_if.fragment_total    <= r.fragment_total;
    req_if.sequence_number   <= r.sequence_number;
    req_if.is_first_fragment <= r.is_first_fragment;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    sb.accept_request(r);
  endtask

  // The settle time covers dropped requests that produce no response.
  task automatic drain_responses();
    req_if.valid <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_ring_size(logic [CfgW-1:0] value);
    drain_responses();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.configure(value);
  endtask

  task automatic run_random(int unsigned count);
    request_t    r;
    int unsigned done;
    done = 0;
    while (done < count) begin
      r = random_request();
      issue(r);
      if (r.command <= CmdQuery) done++;
    end
  endtask

  initial begin
    request_t r;
    sb                = new();
    hold_asked        = 1'b0;
    send_stretch_left = 0;
    send_steady       = 1'b0;
    rst_ni                   <= 1'b0;
    cfg_we                   <= 1'b0;
    cfg_wdata                <= '0;
    req_if.valid             <= 1'b0;
    req_if.command           <= CmdPushSmall;
    req_if.opcode            <= '0;
    req_if.request_key       <= '0;
    req_if.client_address    <= '0;
    req_if.client_index      <= '0;
    req_if.fragment_count    <= '0;
    req_if.fragment_total    <= '0;
    req_if.sequence_number   <= '0;
    req_if.is_first_fragment <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty ring, unknown clients, then extreme payloads.
    issue(build(CmdPop, 0, 0, 0, 0, 0));
    issue(build(CmdQuery, 5, 0, 0, 0, 0));
    issue(build(CmdUpdate, 5, 0, 0, 0, 1));
    r = build(CmdPushSmall, '1, '1, '1, '1, 1'b1);
    r.opcode         = '1;
    r.request_key    = '1;
    r.client_address = '1;
    issue(r);
    r = build(CmdPushSmall, 0, 0, 0, 0, 1'b0);
    r.opcode         = '0;
    r.request_key    = '0;
    r.client_address = '0;
    issue(r);
    // Zero total is stored as one; a second large push for a client is refused.
    issue(build(CmdPushLarge, 1023, 16'hFFFF, 0, '1, 0));
    issue(build(CmdPushLarge, 1023, 1, 2, 0, 0));
    issue(build(CmdPushLarge, 0, 0, 16'hFFFF, 10, 1));
    // Count saturation, with and without the first-fragment flag.
    issue(build(CmdUpdate, 1023, 0, 0, '1, 0));
    issue(build(CmdUpdate, 1023, 0, 0, '1, 1));
    // Stale, same sequence, then a retry with a newer sequence number.
    issue(build(CmdUpdate, 0, 0, 0, 5, 0));
    issue(build(CmdUpdate, 0, 0, 0, 10, 0));
    issue(build(CmdUpdate, 0, 0, 0, 10, 0));
    issue(build(CmdUpdate, 0, 0, 0, 20, 0));
    issue(build(CmdQuery, 0, 0, 0, 0, 0));
    issue(build(cmd_t'(CmdQuery + 1), 0, 0, 0, 0, 0));
    issue(build(cmd_t'(CmdQuery + 3), 0, 0, 0, 0, 0));
    issue(build(CmdPop, 0, 0, 0, 0, 0));
    issue(build(CmdPop, 0, 0, 0, 0, 0));
    issue(build(CmdPop, 0, 0, 0, 0, 0));
    // Popping the large request drops its client from the index.
    issue(build(CmdQuery, 1023, 0, 0, 0, 0));
    issue(build(CmdPop, 0, 0, 0, 0, 0));
    issue(build(CmdPop, 0, 0, 0, 0, 0));

    write_ring_size(2);
    issue(build(CmdPushSmall, 0, 0, 0, 0, 0));
    issue(build(CmdPushLarge, 7, 3, 4, 1, 0));
    issue(build(CmdPop, 0, 0, 0, 0, 0));
    issue(build(CmdPop, 0, 0, 0, 0, 0));

    foreach (RingSizes[i]) begin
      write_ring_size(RingSizes[i]);
      run_random(PhaseRequests / 2);
      if (i == 2) hold_asked = 1'b1;
      if (i == 4) drain_responses();
      run_random(PhaseRequests - PhaseRequests / 2);
    end

    drain_responses();
    if (sb.mismatches == 0) begin
      $display("fragment_tracking_packet_ring_core verification clean");
    end else begin
      $display("fragment_tracking_packet_ring_core verification failed");
    end
    $finish;
  end

endmodule
